[sv/mesf_pkg.sv]
// Shared types and constants of the midpoint ellipse span fill unit.
// Holds the control-word format and the sequencer program; the RTL
// module and the testbench import it. No dependencies.
package mesf_pkg;

   // Fixed port widths
   localparam int RADIUS_PORT_W = 8;
   localparam int COORD_PORT_W  = 9;
   localparam int COLOR_W       = 24;
   localparam int SPAN_W        = 11;
   localparam int LEN_W         = 9;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 3;
   localparam int UPC_W         = 6;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS_ROWS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS_COLS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_ROW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_COL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP_COLOR    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BOTTOM_COLOR = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT_ROW    = 3'd6;

   localparam logic [COORD_PORT_W-1:0] SPLIT_ROW_RESET = 9'd100;

   // Generator phase
   typedef enum logic [1:0] {
      PH_DONE,
      PH_R1,
      PH_R2
   } phase_type;

   // Jump conditions
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_RESTART,
      COND_PH_DONE,
      COND_PH_R2,
      COND_IX_LT_IY,
      COND_Y_NEG,
      COND_DEC_NEG,
      COND_DEC_POS
   } cond_type;

   // ALU operand sources
   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_ACC,
      SRC_PROD,
      SRC_RR2,
      SRC_RC2,
      SRC_IX,
      SRC_IY,
      SRC_DEC
   } src_type;

   // ALU destinations
   typedef enum logic [2:0] {
      DST_NONE,
      DST_ACC,
      DST_IX,
      DST_IY,
      DST_DEC
   } dst_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_QUARTER
   } alu_type;

   // Multiplier operand selects
   typedef enum logic [1:0] {
      MA_TX,
      MA_TY,
      MA_RR2,
      MA_RC2
   } mula_type;

   typedef enum logic [2:0] {
      MB_TX,
      MB_TY,
      MB_PROD,
      MB_RC,
      MB_RC2
   } mulb_type;

   // Result emission
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_UPPER,
      EMIT_LOWER,
      EMIT_DONE
   } emit_type;

   // One control word
   typedef struct packed {
      logic             wait_req;
      emit_type         emit;
      logic             mul_en;
      mula_type         mul_a;
      mulb_type         mul_b;
      alu_type          alu_op;
      src_type          src_a;
      src_type          src_b;
      logic [1:0]       sh_b;
      dst_type          dst;
      logic             x_inc;
      logic             y_dec;
      logic             xy_init;
      logic             phase_wr;
      phase_type        phase_val;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ucode_type;

   // Program entry points
   localparam logic [UPC_W-1:0] A_WAIT  = 6'd0;
   localparam logic [UPC_W-1:0] A_R2CHK = 6'd11;
   localparam logic [UPC_W-1:0] A_EMIT  = 6'd12;
   localparam logic [UPC_W-1:0] A_R1A   = 6'd19;
   localparam logic [UPC_W-1:0] A_UPD2  = 6'd21;
   localparam logic [UPC_W-1:0] A_R2A   = 6'd26;
   localparam logic [UPC_W-1:0] A_DONE  = 6'd28;
   localparam logic [UPC_W-1:0] A_RST   = 6'd29;

   localparam ucode_type UC_NOP = '{
      wait_req:  1'b0,
      emit:      EMIT_NONE,
      mul_en:    1'b0,
      mul_a:     MA_TX,
      mul_b:     MB_TX,
      alu_op:    ALU_ADD,
      src_a:     SRC_ZERO,
      src_b:     SRC_ZERO,
      sh_b:      2'd0,
      dst:       DST_NONE,
      x_inc:     1'b0,
      y_dec:     1'b0,
      xy_init:   1'b0,
      phase_wr:  1'b0,
      phase_val: PH_DONE,
      cond:      COND_NEVER,
      target:    A_WAIT
   };

   // Sequencer program
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      w = UC_NOP;
      unique case (addr)
         // wait for an item, restart goes to the init routine
         6'd0: begin
            w.wait_req = 1'b1;
            w.cond = COND_RESTART; w.target = A_RST;
         end
         // dispatch on phase
         6'd1: begin w.cond = COND_PH_DONE;  w.target = A_DONE;  end
         6'd2: begin w.cond = COND_PH_R2;    w.target = A_R2CHK; end
         6'd3: begin w.cond = COND_IX_LT_IY; w.target = A_EMIT;  end
         // region 2 decision: rc2*tx^2 + 4*rr2*ty^2 - 4*rr2*rc2, then /4
         6'd4: begin w.mul_en = 1'b1; w.mul_a = MA_TX; w.mul_b = MB_TX; end
         6'd5: begin w.mul_en = 1'b1; w.mul_a = MA_RC2; w.mul_b = MB_PROD; end
         6'd6: begin
            w.src_a = SRC_ZERO; w.src_b = SRC_PROD; w.dst = DST_ACC;
            w.mul_en = 1'b1; w.mul_a = MA_TY; w.mul_b = MB_TY;
         end
         6'd7: begin w.mul_en = 1'b1; w.mul_a = MA_RR2; w.mul_b = MB_PROD; end
         6'd8: begin
            w.src_a = SRC_ACC; w.src_b = SRC_PROD; w.sh_b = 2'd2; w.dst = DST_ACC;
            w.mul_en = 1'b1; w.mul_a = MA_RR2; w.mul_b = MB_RC2;
         end
         6'd9: begin
            w.alu_op = ALU_SUB; w.src_a = SRC_ACC; w.src_b = SRC_PROD;
            w.sh_b = 2'd2; w.dst = DST_ACC;
         end
         6'd10: begin
            w.alu_op = ALU_QUARTER; w.src_a = SRC_ACC; w.dst = DST_DEC;
            w.phase_wr = 1'b1; w.phase_val = PH_R2;
         end
         6'd11: begin w.cond = COND_Y_NEG; w.target = A_DONE; end
         // two spans
         6'd12: begin w.emit = EMIT_UPPER; end
         6'd13: begin
            w.emit = EMIT_LOWER;
            w.cond = COND_PH_R2; w.target = A_UPD2;
         end
         // region 1 update
         6'd14: begin
            w.x_inc = 1'b1;
            w.src_a = SRC_IX; w.src_b = SRC_RC2; w.sh_b = 2'd1; w.dst = DST_IX;
            w.cond = COND_DEC_NEG; w.target = A_R1A;
         end
         6'd15: begin
            w.y_dec = 1'b1;
            w.alu_op = ALU_SUB; w.src_a = SRC_IY; w.src_b = SRC_RR2;
            w.sh_b = 2'd1; w.dst = DST_IY;
         end
         6'd16: begin
            w.alu_op = ALU_SUB; w.src_a = SRC_IX; w.src_b = SRC_IY; w.dst = DST_ACC;
         end
         6'd17: begin w.src_a = SRC_ACC; w.src_b = SRC_RC2; w.dst = DST_ACC; end
         6'd18: begin
            w.src_a = SRC_DEC; w.src_b = SRC_ACC; w.dst = DST_DEC;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         6'd19: begin w.src_a = SRC_IX; w.src_b = SRC_RC2; w.dst = DST_ACC; end
         6'd20: begin
            w.src_a = SRC_DEC; w.src_b = SRC_ACC; w.dst = DST_DEC;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         // region 2 update
         6'd21: begin
            w.y_dec = 1'b1;
            w.alu_op = ALU_SUB; w.src_a = SRC_IY; w.src_b = SRC_RR2;
            w.sh_b = 2'd1; w.dst = DST_IY;
            w.cond = COND_DEC_POS; w.target = A_R2A;
         end
         6'd22: begin
            w.x_inc = 1'b1;
            w.src_a = SRC_IX; w.src_b = SRC_RC2; w.sh_b = 2'd1; w.dst = DST_IX;
         end
         6'd23: begin
            w.alu_op = ALU_SUB; w.src_a = SRC_IX; w.src_b = SRC_IY; w.dst = DST_ACC;
         end
         6'd24: begin w.src_a = SRC_ACC; w.src_b = SRC_RR2; w.dst = DST_ACC; end
         6'd25: begin
            w.src_a = SRC_DEC; w.src_b = SRC_ACC; w.dst = DST_DEC;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         6'd26: begin
            w.alu_op = ALU_SUB; w.src_a = SRC_RR2; w.src_b = SRC_IY; w.dst = DST_ACC;
         end
         6'd27: begin
            w.src_a = SRC_DEC; w.src_b = SRC_ACC; w.dst = DST_DEC;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         // finished ellipse
         6'd28: begin
            w.emit = EMIT_DONE;
            w.phase_wr = 1'b1; w.phase_val = PH_DONE;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         // restart: x=0, y=rc, ix=0, iy=2*rr2*rc, dec=(4rc2-4rr2*rc+rr2)/4
         6'd29: begin
            w.mul_en = 1'b1; w.mul_a = MA_RR2; w.mul_b = MB_RC;
            w.xy_init = 1'b1;
            w.src_a = SRC_ZERO; w.src_b = SRC_ZERO; w.dst = DST_IX;
         end
         6'd30: begin
            w.src_a = SRC_ZERO; w.src_b = SRC_PROD; w.sh_b = 2'd1; w.dst = DST_IY;
         end
         6'd31: begin
            w.src_a = SRC_RR2; w.src_b = SRC_RC2; w.sh_b = 2'd2; w.dst = DST_ACC;
         end
         6'd32: begin
            w.alu_op = ALU_SUB; w.src_a = SRC_ACC; w.src_b = SRC_PROD;
            w.sh_b = 2'd2; w.dst = DST_ACC;
         end
         6'd33: begin
            w.alu_op = ALU_QUARTER; w.src_a = SRC_ACC; w.dst = DST_DEC;
            w.phase_wr = 1'b1; w.phase_val = PH_R1;
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
         default: begin
            w.cond = COND_ALWAYS; w.target = A_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/midpoint_ellipse_span_fill_unit.sv]
// Filled-ellipse span generator, two-region midpoint ellipse stepping.
// A microcoded sequencer (program in mesf_pkg) drives one multiplier,
// one adder and the state registers. Depends on mesf_pkg.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_restart
//  rsp      out        rsp_valid/rsp_stall  rsp_span_row, rsp_span_first_col,
//                                           rsp_span_len, rsp_span_color,
//                                           rsp_last, rsp_done_res
//  csr      in         csr_wr_en            csr_index, csr_wdata
//
// One item at a time; the sequencer walks its program one control word per
// cycle while no wait or emit step holds it, so the time per item follows the
// path taken: restart, a finished ellipse (also the region 2 step that finds
// y below zero), a region 2 step, a region 1 step, and the region 2 decision
// on the step that enters region 2. The shared multiplier sets the length of
// the initialization routines. rsp is a single output register: a stalled
// result holds the sequencer at its next emit step. Synchronous reset.
module midpoint_ellipse_span_fill_unit #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // item input
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_restart,
   // span results
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mesf_pkg::SPAN_W-1:0]       rsp_span_row,
   output logic signed [mesf_pkg::SPAN_W-1:0]       rsp_span_first_col,
   output logic        [mesf_pkg::LEN_W-1:0]        rsp_span_len,
   output logic        [mesf_pkg::COLOR_W-1:0]      rsp_span_color,
   output logic                                     rsp_last,
   output logic                                     rsp_done_res,
   // register writes
   input  logic                                     csr_wr_en,
   input  logic        [mesf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic        [mesf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mesf_pkg::*;

   // Widths
   localparam int RW     = (RADIUS_BITS < RADIUS_PORT_W) ? RADIUS_BITS : RADIUS_PORT_W;
   localparam int SW     = 2 * RW;
   localparam int XW     = COORD_BITS - 1;
   localparam int YW     = RW + 2;
   localparam int TXW    = XW + 1;
   localparam int MA_M1  = (SW > TXW) ? SW : TXW;
   localparam int MAW    = ((MA_M1 > YW) ? MA_M1 : YW) + 1;
   localparam int SQW    = (2 * TXW > 2 * YW) ? 2 * TXW : 2 * YW;
   localparam int MBW    = ((SQW > SW) ? SQW : SW) + 1;
   localparam int PW     = MAW + MBW;
   localparam int DW0    = SW + SQW + 4;
   localparam int DW     = (DW0 > PW + 3) ? DW0 : PW + 3;
   localparam int IW     = SW + ((XW > RW) ? XW : RW) + 3;
   localparam int RSUM_W = ((XW > COORD_PORT_W) ? XW : COORD_PORT_W) + 2;
   localparam int CSUM_W = ((YW > COORD_PORT_W + 1) ? YW : COORD_PORT_W + 1) + 1;

   // Configuration registers
   logic [RW-1:0]           radius_rows_ff, radius_cols_ff;
   logic [COORD_PORT_W-1:0] center_row_ff, center_col_ff, split_row_ff;
   logic [COLOR_W-1:0]      top_color_ff, bottom_color_ff;
   logic [SW-1:0]           rr2_ff, rc2_ff;

   // Sequencer and datapath state
   logic [UPC_W-1:0]        upc_ff, upc_in;
   ucode_type               ctl;
   logic                    step_go;
   logic                    cond_true;
   phase_type               phase_ff, phase_in;
   logic [XW-1:0]           x_ff, x_in;
   logic signed [YW-1:0]    y_ff, y_in;
   logic signed [IW-1:0]    ix_ff, ix_in, iy_ff, iy_in;
   logic signed [DW-1:0]    dec_ff, dec_in, acc_ff, acc_in;
   logic signed [PW-1:0]    prod_ff, prod_in;

   // Datapath signals
   logic [TXW-1:0]          tx;
   logic signed [YW-1:0]    ty;
   logic signed [MAW-1:0]   mul_a;
   logic signed [MBW-1:0]   mul_b;
   logic signed [DW-1:0]    opa, opb, opb_sh, alu_bias, alu_res;

   // Output register
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SPAN_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [LEN_W-1:0]        rsp_len_ff, rsp_len_in;
   logic [COLOR_W-1:0]      rsp_color_ff, rsp_color_in;
   logic                    rsp_last_ff, rsp_last_in, rsp_done_ff, rsp_done_in;
   logic signed [RSUM_W-1:0] row_up, row_dn, row_sel;
   logic [CSUM_W-1:0]       col_wide;

   assign ctl = ucode_rom(upc_ff);

   // Step handshake: wait steps take an item, emit steps need the output slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctl.wait_req;

   always_comb begin
      step_go = 1'b1;
      if (ctl.wait_req) begin
         step_go = req_valid;
      end else if (ctl.emit != EMIT_NONE) begin
         step_go = out_free;
      end
   end

   // Jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_RESTART:  cond_true = req_restart;
         COND_PH_DONE:  cond_true = (phase_ff == PH_DONE);
         COND_PH_R2:    cond_true = (phase_ff == PH_R2);
         COND_IX_LT_IY: cond_true = (ix_ff < iy_ff);
         COND_Y_NEG:    cond_true = y_ff[YW-1];
         COND_DEC_NEG:  cond_true = dec_ff[DW-1];
         COND_DEC_POS:  cond_true = !dec_ff[DW-1] && (dec_ff != '0);
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      if (step_go) begin
         upc_in = cond_true ? ctl.target : upc_ff + UPC_W'(1);
      end
   end

   // Multiplier operands: tx = 2x+1, ty = y-1
   assign tx = {x_ff, 1'b1};
   assign ty = y_ff - YW'(1);

   always_comb begin
      unique case (ctl.mul_a)
         MA_TX:   mul_a = signed'(MAW'(tx));
         MA_TY:   mul_a = MAW'(ty);
         MA_RR2:  mul_a = signed'(MAW'(rr2_ff));
         MA_RC2:  mul_a = signed'(MAW'(rc2_ff));
         default: mul_a = '0;
      endcase
      unique case (ctl.mul_b)
         MB_TX:   mul_b = signed'(MBW'(tx));
         MB_TY:   mul_b = MBW'(ty);
         MB_PROD: mul_b = MBW'(prod_ff);
         MB_RC:   mul_b = signed'(MBW'(radius_cols_ff));
         MB_RC2:  mul_b = signed'(MBW'(rc2_ff));
         default: mul_b = '0;
      endcase
   end

   assign prod_in = (step_go && ctl.mul_en) ? mul_a * mul_b : prod_ff;

   // ALU operand selection
   always_comb begin
      unique case (ctl.src_a)
         SRC_ZERO: opa = '0;
         SRC_ACC:  opa = acc_ff;
         SRC_PROD: opa = DW'(prod_ff);
         SRC_RR2:  opa = signed'(DW'(rr2_ff));
         SRC_RC2:  opa = signed'(DW'(rc2_ff));
         SRC_IX:   opa = DW'(ix_ff);
         SRC_IY:   opa = DW'(iy_ff);
         SRC_DEC:  opa = dec_ff;
         default:  opa = '0;
      endcase
      unique case (ctl.src_b)
         SRC_ZERO: opb = '0;
         SRC_ACC:  opb = acc_ff;
         SRC_PROD: opb = DW'(prod_ff);
         SRC_RR2:  opb = signed'(DW'(rr2_ff));
         SRC_RC2:  opb = signed'(DW'(rc2_ff));
         SRC_IX:   opb = DW'(ix_ff);
         SRC_IY:   opb = DW'(iy_ff);
         SRC_DEC:  opb = dec_ff;
         default:  opb = '0;
      endcase
   end

   // ALU: add, subtract, or divide by 4 rounding toward zero
   assign opb_sh   = opb <<< ctl.sh_b;
   assign alu_bias = opa + (opa[DW-1] ? DW'(3) : DW'(0));

   always_comb begin
      unique case (ctl.alu_op)
         ALU_ADD:     alu_res = opa + opb_sh;
         ALU_SUB:     alu_res = opa - opb_sh;
         ALU_QUARTER: alu_res = alu_bias >>> 2;
         default:     alu_res = opa;
      endcase
   end

   // Register writes of the step
   always_comb begin
      acc_in   = acc_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      dec_in   = dec_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      phase_in = phase_ff;
      if (step_go) begin
         case (ctl.dst)
            DST_ACC: acc_in = alu_res;
            DST_IX:  ix_in  = IW'(alu_res);
            DST_IY:  iy_in  = IW'(alu_res);
            DST_DEC: dec_in = alu_res;
            default: ;
         endcase
         if (ctl.xy_init) begin
            x_in = '0;
            y_in = signed'(YW'(radius_cols_ff));
         end else begin
            if (ctl.x_inc) x_in = x_ff + XW'(1);
            if (ctl.y_dec) y_in = y_ff - YW'(1);
         end
         if (ctl.phase_wr) phase_in = ctl.phase_val;
      end
   end

   // Span fields
   assign row_up   = RSUM_W'(center_row_ff) + RSUM_W'(x_ff);
   assign row_dn   = RSUM_W'(center_row_ff) - RSUM_W'(x_ff);
   assign row_sel  = (ctl.emit == EMIT_LOWER) ? row_dn : row_up;
   assign col_wide = CSUM_W'(center_col_ff) - CSUM_W'(y_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (step_go && ctl.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
         if (ctl.emit == EMIT_DONE) begin
            rsp_row_in   = '0;
            rsp_col_in   = '0;
            rsp_len_in   = '0;
            rsp_color_in = '0;
            rsp_last_in  = 1'b1;
            rsp_done_in  = 1'b1;
         end else begin
            rsp_row_in   = SPAN_W'(row_sel);
            rsp_col_in   = signed'(SPAN_W'(col_wide));
            rsp_len_in   = LEN_W'(y_ff) << 1;
            rsp_color_in = (row_sel < signed'(RSUM_W'(split_row_ff))) ?
                           top_color_ff : bottom_color_ff;
            rsp_last_in  = (ctl.emit == EMIT_LOWER);
            rsp_done_in  = 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State
   always_ff @(posedge clock) begin
      // squares follow the radius registers
      rr2_ff <= SW'(radius_rows_ff) * SW'(radius_rows_ff);
      rc2_ff <= SW'(radius_cols_ff) * SW'(radius_cols_ff);
      // datapath payload
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         radius_rows_ff  <= RW'(1);
         radius_cols_ff  <= RW'(1);
         center_row_ff   <= '0;
         center_col_ff   <= '0;
         top_color_ff    <= '0;
         bottom_color_ff <= '0;
         split_row_ff    <= SPLIT_ROW_RESET;
         upc_ff          <= A_WAIT;
         phase_ff        <= PH_DONE;
         x_ff            <= '0;
         y_ff            <= '0;
         ix_ff           <= '0;
         iy_ff           <= '0;
         dec_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_RADIUS_ROWS:  radius_rows_ff  <= csr_wdata[RW-1:0];
               REG_RADIUS_COLS:  radius_cols_ff  <= csr_wdata[RW-1:0];
               REG_CENTER_ROW:   center_row_ff   <= csr_wdata[COORD_PORT_W-1:0];
               REG_CENTER_COL:   center_col_ff   <= csr_wdata[COORD_PORT_W-1:0];
               REG_TOP_COLOR:    top_color_ff    <= csr_wdata[COLOR_W-1:0];
               REG_BOTTOM_COLOR: bottom_color_ff <= csr_wdata[COLOR_W-1:0];
               REG_SPLIT_ROW:    split_row_ff    <= csr_wdata[COORD_PORT_W-1:0];
               default: ;
            endcase
         end
         upc_ff       <= upc_in;
         phase_ff     <= phase_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         ix_ff        <= ix_in;
         iy_ff        <= iy_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_span_row       = rsp_row_ff;
   assign rsp_span_first_col = rsp_col_ff;
   assign rsp_span_len       = rsp_len_ff;
   assign rsp_span_color     = rsp_color_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_done_res       = rsp_done_ff;

endmodule

[tb/midpoint_ellipse_span_fill_unit_tb.sv]
// Self-checking testbench for the midpoint ellipse span fill unit.
// Predicts the span items of each request from its own ellipse stepping model
// and checks every result item in order. Depends on mesf_pkg and the unit.
module midpoint_ellipse_span_fill_unit_tb;
   import mesf_pkg::*;

   localparam int COORD_BITS = 10;
   localparam int RADIUS_BITS = 8;
   localparam int X_MASK = (1 << (COORD_BITS - 1)) - 1;
   localparam bit ITEM_STEP = 1'b0;
   localparam bit ITEM_RESTART = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;
   localparam int ITEM_TARGET = 1250;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT = 300;

   // One expected span item
   typedef struct packed {
      logic signed [SPAN_W-1:0] row;
      logic signed [SPAN_W-1:0] first_col;
      logic [LEN_W-1:0]         len;
      logic [COLOR_W-1:0]       color;
      logic                     last;
      logic                     done;
   } span_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SPAN_W-1:0] rsp_span_row;
   logic signed [SPAN_W-1:0] rsp_span_first_col;
   logic [LEN_W-1:0] rsp_span_len;
   logic [COLOR_W-1:0] rsp_span_color;
   logic rsp_last;
   logic rsp_done_res;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Stimulus and expectation stores
   bit pending_items[$];
   span_rec_type span_expect[$];
   int items_sent = 0;
   int items_taken = 0;
   int mismatch_count = 0;

   // Predictor copy of the registers
   int cfg_rr = 1;
   int cfg_rc = 1;
   int cfg_crow = 0;
   int cfg_ccol = 0;
   int cfg_top = 0;
   int cfg_bottom = 0;
   int cfg_split = int'(SPLIT_ROW_RESET);

   // Predictor copy of the stepping state
   phase_type gen_phase = PH_DONE;
   int gen_x = 0;
   int gen_y = 0;
   longint gen_ix = 0;
   longint gen_iy = 0;
   longint gen_dec = 0;

   // Sender and receiver pacing
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_off_done = 1'b0;

   midpoint_ellipse_span_fill_unit #(
      .COORD_BITS(COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_span_row(rsp_span_row),
      .rsp_span_first_col(rsp_span_first_col),
      .rsp_span_len(rsp_span_len),
      .rsp_span_color(rsp_span_color),
      .rsp_last(rsp_last),
      .rsp_done_res(rsp_done_res),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Span for the current y on a given row; rows are compared unclipped
   function automatic span_rec_type span_at(int row, bit is_last);
      span_rec_type s;
      s.row = SPAN_W'(row);
      s.first_col = SPAN_W'(cfg_ccol - gen_y);
      s.len = LEN_W'(2 * gen_y);
      s.color = (row < cfg_split) ? COLOR_W'(cfg_top) : COLOR_W'(cfg_bottom);
      s.last = is_last;
      s.done = 1'b0;
      return s;
   endfunction

   // Advance the ellipse by one accepted item and queue its span items
   task automatic predict_spans(input bit restart);
      longint rr2;
      longint rc2;
      longint tx;
      longint ty;
      rr2 = longint'(cfg_rr) * cfg_rr;
      rc2 = longint'(cfg_rc) * cfg_rc;
      if (restart) begin
         gen_x = 0;
         gen_y = cfg_rc;
         gen_ix = 0;
         gen_iy = 2 * rr2 * gen_y;
         gen_dec = (4 * rc2 - 4 * rr2 * cfg_rc + rr2) / 4;
         gen_phase = PH_R1;
         return;
      end
      // region change: compute the region 2 decision, then step there at once
      if (gen_phase == PH_R1 && !(gen_ix < gen_iy)) begin
         tx = 2 * longint'(gen_x) + 1;
         ty = longint'(gen_y) - 1;
         gen_dec = (rc2 * tx * tx + 4 * rr2 * ty * ty - 4 * rr2 * rc2) / 4;
         gen_phase = PH_R2;
      end
      if (gen_phase == PH_R2 && gen_y < 0)
         gen_phase = PH_DONE;
      if (gen_phase == PH_DONE) begin
         span_expect.push_back('{row: '0, first_col: '0, len: '0, color: '0,
                                 last: 1'b1, done: 1'b1});
         return;
      end
      span_expect.push_back(span_at(cfg_crow + gen_x, 1'b0));
      span_expect.push_back(span_at(cfg_crow - gen_x, 1'b1));
      if (gen_phase == PH_R1) begin
         gen_x++;
         gen_ix += 2 * rc2;
         if (gen_dec < 0) begin
            gen_dec += gen_ix + rc2;
         end else begin
            gen_y--;
            gen_iy -= 2 * rr2;
            gen_dec += gen_ix - gen_iy + rc2;
         end
      end else begin
         gen_y--;
         gen_iy -= 2 * rr2;
         if (gen_dec > 0) begin
            gen_dec += rr2 - gen_iy;
         end else begin
            gen_x++;
            gen_ix += 2 * rc2;
            gen_dec += gen_ix - gen_iy + rr2;
         end
      end
      gen_x = gen_x & X_MASK;
   endtask

   // Register write at the next edge; predictor copy follows at once (unit is idle)
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_RADIUS_ROWS:  cfg_rr = int'(data[RADIUS_PORT_W-1:0]);
         REG_RADIUS_COLS:  cfg_rc = int'(data[RADIUS_PORT_W-1:0]);
         REG_CENTER_ROW:   cfg_crow = int'(data[COORD_PORT_W-1:0]);
         REG_CENTER_COL:   cfg_ccol = int'(data[COORD_PORT_W-1:0]);
         REG_TOP_COLOR:    cfg_top = int'(data[COLOR_W-1:0]);
         REG_BOTTOM_COLOR: cfg_bottom = int'(data[COLOR_W-1:0]);
         REG_SPLIT_ROW:    cfg_split = int'(data[COORD_PORT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_items(input bit kind, input int count);
      repeat (count) pending_items.push_back(kind);
      items_sent += count;
   endtask

   // Wait until every item is taken and every span item is back, then let
   // any trailing update work finish
   task automatic settle();
      while (pending_items.size() != 0 || req_valid || span_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 511;
         default: return $urandom_range(0, 511);
      endcase
   endfunction

   function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected 'h%0h got 'h%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Item driver: bursts of items with random gaps
   always @(posedge clock) begin : item_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_spans(req_restart);
            items_taken <= items_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_restart <= pending_items.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(0, 3);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: changing patterns plus one long hold-off
   always @(posedge clock) begin : stall_pattern
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_off_done && items_taken >= HOLD_OFF_AT) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 6);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Result monitor: compare each accepted span item with the oldest expectation
   always @(posedge clock) begin : span_monitor
      span_rec_type want;
      int bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (span_expect.size() == 0) begin
            $error("span item with none expected: row 'h%0h len 'h%0h",
                   rsp_span_row, rsp_span_len);
            mismatch_count++;
         end else begin
            want = span_expect.pop_front();
            bad = field_bad("span_row", want.row, rsp_span_row)
                + field_bad("span_first_col", want.first_col, rsp_span_first_col)
                + field_bad("span_len", want.len, rsp_span_len)
                + field_bad("span_color", want.color, rsp_span_color)
                + field_bad("last", want.last, rsp_last)
                + field_bad("done_res", want.done, rsp_done_res);
            if (bad != 0) mismatch_count++;
         end
      end
   end

   initial begin : stimulus
      int rad_r;
      int rad_c;
      int crow;
      int split;
      int full;
      int shape;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: steps before any restart finish at once, then a
      // unit ellipse through the region change to its end
      push_items(ITEM_STEP, 2);
      push_items(ITEM_RESTART, 1);
      push_items(ITEM_STEP, 4);
      settle();

      // Largest radii, far corner center, extreme colors and split
      write_reg(REG_RADIUS_ROWS, 24'hFFFFFF);
      write_reg(REG_RADIUS_COLS, 24'h0000FF);
      write_reg(REG_CENTER_ROW, 24'd511);
      write_reg(REG_CENTER_COL, 24'd0);
      write_reg(REG_TOP_COLOR, 24'hFFFFFF);
      write_reg(REG_BOTTOM_COLOR, 24'h000000);
      write_reg(REG_SPLIT_ROW, 24'd511);
      end_writes();
      push_items(ITEM_RESTART, 1);
      push_items(ITEM_STEP, 6);
      settle();

      // Zero row radius: region 2 from the first step; restart mid-ellipse
      write_reg(REG_RADIUS_ROWS, 24'hABCD00);
      write_reg(REG_RADIUS_COLS, 24'd3);
      write_reg(REG_CENTER_ROW, 24'd0);
      write_reg(REG_CENTER_COL, 24'd511);
      write_reg(REG_TOP_COLOR, 24'h000000);
      write_reg(REG_BOTTOM_COLOR, 24'hFFFFFF);
      write_reg(REG_SPLIT_ROW, 24'd0);
      write_reg(REG_SPARE, 24'h5A5A5A);
      end_writes();
      push_items(ITEM_RESTART, 1);
      push_items(ITEM_STEP, 6);
      settle();

      // Random settings, mostly complete ellipses of small radius
      while (items_sent < ITEM_TARGET) begin
         shape = $urandom_range(0, 15);
         if (shape == 0) begin
            rad_r = $urandom_range(100, 255);
            rad_c = $urandom_range(100, 255);
         end else if (shape == 1) begin
            rad_r = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            rad_c = (rad_r == 0) ? $urandom_range(0, 12) : 0;
         end else begin
            rad_r = $urandom_range(1, 12);
            rad_c = $urandom_range(1, 12);
         end
         crow = pick_coord();
         if ($urandom_range(0, 1)) begin
            split = $urandom_range(0, 511);
         end else begin
            split = crow + $urandom_range(0, 24) - 12;
            if (split < 0) split = 0;
            if (split > 511) split = 511;
         end
         write_reg(REG_RADIUS_ROWS, {16'($urandom_range(0, 65535)), 8'(rad_r)});
         write_reg(REG_RADIUS_COLS, {16'($urandom_range(0, 65535)), 8'(rad_c)});
         write_reg(REG_CENTER_ROW, CSR_DATA_W'(crow));
         write_reg(REG_CENTER_COL, CSR_DATA_W'(pick_coord()));
         write_reg(REG_TOP_COLOR, CSR_DATA_W'($urandom));
         write_reg(REG_BOTTOM_COLOR, CSR_DATA_W'($urandom));
         write_reg(REG_SPLIT_ROW, CSR_DATA_W'(split));
         if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, CSR_DATA_W'($urandom));
         end_writes();

         full = rad_r + rad_c + 3;
         if (full > 48) full = 48;
         case ($urandom_range(0, 9))
            7: begin
               // restart part way through
               push_items(ITEM_RESTART, 1);
               push_items(ITEM_STEP, $urandom_range(1, full));
               push_items(ITEM_RESTART, 1);
               push_items(ITEM_STEP, full);
            end
            8: begin
               repeat (20) push_items($urandom_range(0, 1), 1);
            end
            9: begin
               // carry on from the previous state under new settings
               push_items(ITEM_STEP, $urandom_range(1, 10));
            end
            default: begin
               push_items(ITEM_RESTART, 1);
               push_items(ITEM_STEP, full);
            end
         endcase
         settle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #15_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
sv/mesf_pkg.sv
sv/midpoint_ellipse_span_fill_unit.sv
tb/midpoint_ellipse_span_fill_unit_tb.sv
